// ===== rtl/ist_pkg.sv =====
// Shared types and constants for the interpolation search table.
// No dependencies; every other file in rtl/ imports this package.
package ist_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_ID_WIDTH    = 32;

    // Fixed field widths
    localparam int COUNT_W    = 11;
    localparam int IDX_W      = 10;
    localparam int IN_ID_W    = 32;
    localparam int POS_W      = 10;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD_HI,
        S_TEST,
        S_SCALE,
        S_PROBE,
        S_DONE
    } ist_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV
    } ist_sc_state_t;

endpackage

// ===== rtl/ist_in_if.sv =====
// Input channel: valid/ready plus one input word (load or search).
// Depends on ist_pkg for field widths.
interface ist_in_if import ist_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0]   entry_index;
    logic [IN_ID_W-1:0] entry_id;
    logic [IN_ID_W-1:0] search_key;

    modport source (output valid, action, entry_index, entry_id, search_key, input ready);
    modport sink   (input valid, action, entry_index, entry_id, search_key, output ready);
endinterface

// ===== rtl/ist_out_if.sv =====
// Output channel: valid/ready plus one result word.
// Depends on ist_pkg for field widths.
interface ist_out_if import ist_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

// ===== rtl/ist_table.sv =====
// Identifier table: one write port, one read port with registered data.
// Depends on ist_pkg for the default depth and width.
module ist_table import ist_pkg::*; #(
    parameter int DEPTH = DEF_TABLE_DEPTH,
    parameter int DW    = DEF_ID_WIDTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data
);

    logic [DW-1:0] id_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= id_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ist_scale.sv =====
// Bit-serial scaled quotient floor(d * span / den) for the probe offset.
// Shift-add multiply over the SPAN_W span bits, then restoring divide for SPAN_W
// quotient bits. Requires d <= den, den > 0, so the quotient fits in SPAN_W bits.
// Depends on ist_pkg.
module ist_scale import ist_pkg::*; #(
    parameter int ID_WIDTH = DEF_ID_WIDTH,
    parameter int SPAN_W   = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ID_WIDTH-1:0] d,
    input  logic [SPAN_W-1:0]   span,
    input  logic [ID_WIDTH-1:0] den,
    output logic                done,
    output logic [SPAN_W-1:0]   quot
);

    localparam int CNT_W = $clog2(SPAN_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SPAN_W - 1);

    ist_sc_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [ID_WIDTH-1:0] hi_reg, hi_next;
    logic [SPAN_W-1:0]   lo_reg, lo_next;
    logic [ID_WIDTH-1:0] d_reg, d_next;
    logic [ID_WIDTH-1:0] den_reg, den_next;
    logic [SPAN_W-1:0]   span_reg, span_next;

    logic [ID_WIDTH:0]          mul_sum;
    logic [ID_WIDTH+SPAN_W:0]   mul_shift;
    logic [ID_WIDTH:0]          div_trial;
    logic                       div_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        d_reg    <= d_next;
        den_reg  <= den_next;
        span_reg <= span_next;
    end

    always_comb
    begin
        // multiply step: add d when the current multiplier bit is set, shift right
        mul_sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, d_reg} : '0);
        mul_shift = {mul_sum, lo_reg} >> 1;
        // divide step: bring down the next product bit
        div_trial = {hi_reg, lo_reg[SPAN_W-1]};
        div_bit   = (div_trial >= {1'b0, den_reg});

        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        d_next     = d_reg;
        den_next   = den_reg;
        span_next  = span_reg;

        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    d_next     = d;
                    den_next   = den;
                    span_next  = span;
                    hi_next    = '0;
                    lo_next    = span;
                    cnt_next   = '0;
                    state_next = SC_MUL;
                end
            end
            SC_MUL:
            begin
                hi_next = mul_shift[ID_WIDTH+SPAN_W-1:SPAN_W];
                lo_next = mul_shift[SPAN_W-1:0];
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = SC_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SC_DIV:
            begin
                hi_next = div_bit ? ID_WIDTH'(div_trial - {1'b0, den_reg})
                                  : div_trial[ID_WIDTH-1:0];
                lo_next = SPAN_W'({lo_reg, div_bit});
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = SC_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = lo_reg;

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> lo_reg <= span_reg)
        else $error("scaled quotient exceeds span");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == SC_IDLE)
        else $error("scale started while busy");

endmodule

// ===== rtl/interpolation_search_table_core.sv =====
// Top level of the interpolation search table: APB register, sequencer,
// table memory and bit-serial probe scaler.
// Depends on ist_pkg, ist_in_if, ist_out_if, ist_table, ist_scale.
//
//  channel  | dir | handshake          | word contents
//  ---------+-----+--------------------+-----------------------------------------
//  in_ch    | in  | valid/ready        | action, entry_index, entry_id, search_key
//  out_ch   | out | valid/ready        | found, position
//  apb      | in  | psel/penable/pready| entry_count at byte address 0
//
// A load word writes the table in the same cycle that it is accepted.
// A search loops over states: the bounds check, reads of id[low] and id[high],
// the bounds test, the scaler (multiply steps, divide steps, then done) for the
// probe offset, and the probe read. It ends when the bounds test ends it, the
// bounds cross, or a probe hits, and then loads the output register.
// Empty-table searches go straight to the done state, with no table read.
// Reset clears control state only; table contents are undefined until loaded.
// in_ch is taken only while the sequencer is idle; a result waiting on out_ch
// does not block the next word, but the next search stalls until it drains.
module interpolation_search_table_core import ist_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ist_in_if.sink                in_ch,
    ist_out_if.source             out_ch
);

    localparam int AW = $clog2(TABLE_DEPTH);
    // signed bound width: high can step to -1, low can step to TABLE_DEPTH
    localparam int BW = AW + 2;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? APB_DATA_W'(entry_count_reg) : '0;

    always_comb
    begin
        entry_count_next = cfg_wr ? pwdata[COUNT_W-1:0] : entry_count_reg;
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    ist_state_t state_reg, state_next;
    logic signed [BW-1:0] low_reg, low_next;
    logic signed [BW-1:0] high_reg, high_next;
    logic [ID_WIDTH-1:0]  key_reg, key_next;
    logic [ID_WIDTH-1:0]  lid_reg, lid_next;
    logic [AW-1:0]        mid_reg, mid_next;
    logic                 res_found_reg, res_found_next;
    logic [POS_W-1:0]     res_pos_reg, res_pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [POS_W-1:0]     out_pos_reg, out_pos_next;

    // table and scaler hookup
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [ID_WIDTH-1:0]  wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [ID_WIDTH-1:0]  rd_data;
    logic                 sc_start;
    logic [ID_WIDTH-1:0]  sc_d;
    logic [AW-1:0]        sc_span;
    logic [ID_WIDTH-1:0]  sc_den;
    logic                 sc_done;
    logic [AW-1:0]        sc_quot;

    logic [31:0]          n_eff;
    logic [AW-1:0]        mid_calc;
    logic signed [BW-1:0] mid_ext;
    logic                 in_acc;
    logic                 out_load;

    ist_table #(
        .DEPTH (TABLE_DEPTH),
        .DW    (ID_WIDTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ist_scale #(
        .ID_WIDTH (ID_WIDTH),
        .SPAN_W   (AW)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sc_start),
        .d     (sc_d),
        .span  (sc_span),
        .den   (sc_den),
        .done  (sc_done),
        .quot  (sc_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg       <= low_next;
        high_reg      <= high_next;
        key_reg       <= key_next;
        lid_reg       <= lid_next;
        mid_reg       <= mid_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign in_acc          = in_ch.valid && in_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.found    = out_found_reg;
    assign out_ch.position = out_pos_reg;

    // searched entries: entry_count clamped to the table
    assign n_eff = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                           : 32'(entry_count_reg);
    assign mid_calc = low_reg[AW-1:0] + sc_quot;
    assign mid_ext  = signed'({2'b00, mid_reg});

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        key_next       = key_reg;
        lid_next       = lid_reg;
        mid_next       = mid_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        out_load       = 1'b0;

        wr_en    = 1'b0;
        wr_addr  = AW'(in_ch.entry_index);
        wr_data  = ID_WIDTH'(in_ch.entry_id);
        rd_en    = 1'b0;
        rd_addr  = low_reg[AW-1:0];
        sc_start = 1'b0;
        sc_d     = key_reg - lid_reg;
        sc_span  = AW'(high_reg - low_reg);
        sc_den   = rd_data - lid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.action == ACT_LOAD)
                    begin
                        // positions past the table are dropped
                        wr_en = (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));
                    end
                    else
                    begin
                        key_next  = ID_WIDTH'(in_ch.search_key);
                        low_next  = '0;
                        high_next = signed'(BW'(n_eff - 32'd1));
                        if (n_eff == 32'd0)
                        begin
                            // empty table: not found, nothing read
                            res_found_next = 1'b0;
                            res_pos_next   = '0;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (low_reg > high_reg)
                begin
                    // bounds crossed (unsorted table)
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = low_reg[AW-1:0];
                    state_next = S_RD_HI;
                end
            end
            S_RD_HI:
            begin
                lid_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = high_reg[AW-1:0];
                state_next = S_TEST;
            end
            S_TEST:
            begin
                // rd_data holds id[high] here
                if (rd_data == lid_reg || key_reg < lid_reg || key_reg > rd_data)
                begin
                    res_found_next = (lid_reg == key_reg);
                    res_pos_next   = (lid_reg == key_reg) ? POS_W'(low_reg[AW-1:0]) : '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    sc_start   = 1'b1;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (sc_done)
                begin
                    mid_next   = mid_calc;
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (rd_data < key_reg)
                begin
                    low_next   = mid_ext + BW'(1);
                    state_next = S_CHECK;
                end
                else if (key_reg < rd_data)
                begin
                    high_next  = mid_ext - BW'(1);
                    state_next = S_CHECK;
                end
                else
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = POS_W'(mid_reg);
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free or draining
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_found_next = out_load ? res_found_reg : out_found_reg;
        out_pos_next   = out_load ? res_pos_reg : out_pos_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // probe always lands inside the current bounds
    a_mid_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> (mid_ext >= low_reg && mid_ext <= high_reg))
        else $error("probe position outside bounds");

    // bounds only narrow while a search is running
    a_low_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && $past(state_reg) != S_IDLE) |-> low_reg >= $past(low_reg))
        else $error("low bound moved down during search");

    a_high_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && $past(state_reg) != S_IDLE) |-> high_reg <= $past(high_reg))
        else $error("high bound moved up during search");

endmodule

// ===== test/tb.sv =====
// Testbench for interpolation_search_table_core: loads sorted and unsorted id tables,
// searches them under random stalls and checks every result against an in-bench predictor.
// Depends on rtl/ist_pkg.sv, rtl/ist_in_if.sv, rtl/ist_out_if.sv and the core RTL.
module tb;
    import ist_pkg::*;

    localparam int TABLE_DEPTH   = DEF_TABLE_DEPTH;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 4;      // lets the last load write settle
    localparam int DRAIN_CYCLES  = 64;     // quiet time after the last result
    localparam int CHOKE_CYCLES  = 400;    // long receiver hold-off
    localparam int RANDOM_WORDS  = 200;
    localparam int RUN_LIMIT     = 1_000_000;
    localparam int MAX_COUNT     = (1 << COUNT_W) - 1;

    // entry_count sits at byte address 0 (register index in paddr[2])
    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

    typedef struct packed {
        logic               action;
        logic [IDX_W-1:0]   entry_index;
        logic [IN_ID_W-1:0] entry_id;
        logic [IN_ID_W-1:0] search_key;
    } table_word_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } lookup_result_t;

    // How a phase lays out the searched prefix of the table
    typedef enum int {
        FILL_UNIFORM,
        FILL_DUPES,
        FILL_SKEWED,
        FILL_SHUFFLED,
        FILL_FLAT,
        FILL_KEEP
    } fill_kind_t;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b1;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ist_in_if  in_ch ();
    ist_out_if out_ch ();

    interpolation_search_table_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: table contents and entry_count as the block sees
    // them, updated in word acceptance order.
    // ------------------------------------------------------------------
    bit [IN_ID_W-1:0]   id_mirror [TABLE_DEPTH];
    logic [COUNT_W-1:0] count_setting = '0;
    lookup_result_t     awaited_results [$];

    // Stimulus side: words waiting for the driver, and the table contents
    // that the queued loads will leave behind (used to pick search keys).
    table_word_t        queued_words [$];
    bit [IN_ID_W-1:0]   planned_ids [TABLE_DEPTH];
    int                 words_queued = 0;

    int error_count  = 0;
    int results_seen = 0;
    int cycle_count  = 0;

    // Long receiver hold-off, requested by the stimulus, counted on its own
    int choke_requests = 0;
    int choke_served   = 0;
    int choke_left     = 0;

    // Driver and monitor working state
    table_word_t offered;
    bit          offer_next;
    int          sender_gap    = 0;
    bit          sender_steady = 1'b0;
    int          sink_wait     = 0;
    bit          sink_steady   = 1'b0;

    // Interpolation search over the first entry_count mirrored entries.
    // Probe = low + (key - id[low]) * (high - low) / (id[high] - id[low]),
    // formed at 64 bits so the product never wraps.
    function automatic lookup_result_t interp_lookup(logic [IN_ID_W-1:0] key);
        lookup_result_t   r;
        int               n;
        int               lo;
        int               hi;
        int               mid;
        bit [IN_ID_W-1:0] lid;
        bit [IN_ID_W-1:0] hid;
        bit [IN_ID_W-1:0] mid_id;
        bit [63:0]        key_off;
        bit [63:0]        span;
        bit [63:0]        den;
        r = '0;
        // count beyond the table clips to the table depth
        n = (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
        // empty table: not found, position 0, nothing read
        if (n == 0)
            return r;
        lo = 0;
        hi = n - 1;
        forever
        begin
            // crossed bounds (unsorted table) end the search as a miss
            if (lo > hi)
                return r;
            lid = id_mirror[lo];
            hid = id_mirror[hi];
            if (hid == lid || key < lid || key > hid)
                break;
            key_off = 64'(key) - 64'(lid);
            span    = 64'(hi - lo);
            den     = 64'(hid) - 64'(lid);
            mid     = lo + int'((key_off * span) / den);
            mid_id  = id_mirror[mid];
            if (mid_id < key)
                lo = mid + 1;
            else if (key < mid_id)
                hi = mid - 1;
            else
            begin
                r.found    = 1'b1;
                r.position = POS_W'(mid);
                return r;
            end
        end
        if (id_mirror[lo] == key)
        begin
            r.found    = 1'b1;
            r.position = POS_W'(lo);
        end
        return r;
    endfunction

    // Apply one accepted word to the mirror; a search queues its result.
    function automatic void absorb_word(table_word_t w);
        if (w.action == ACT_LOAD)
            id_mirror[w.entry_index] = w.entry_id;
        else
            awaited_results.push_back(interp_lookup(w.search_key));
    endfunction

    function automatic int draw_gap(bit steady);
        return steady ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic report_mismatch(string what, int seq, int got, int want);
        $display("MISMATCH result %0d %s: got %0h, want %0h", seq, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued words on in_ch. After each accepted word it
    // draws an idle gap; gaps are skipped while the sender runs steady.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.action      <= ACT_LOAD;
            in_ch.entry_index <= '0;
            in_ch.entry_id    <= '0;
            in_ch.search_key  <= '0;
            sender_gap = 0;
        end
        else
        begin
            offer_next = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                absorb_word(offered);
                offer_next = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    sender_steady = !sender_steady;
                sender_gap = draw_gap(sender_steady);
            end
            if (!offer_next)
            begin
                if (sender_gap > 0)
                    sender_gap--;
                else if (queued_words.size() != 0)
                begin
                    offered    = queued_words.pop_front();
                    offer_next = 1'b1;
                    in_ch.action      <= offered.action;
                    in_ch.entry_index <= offered.entry_index;
                    in_ch.entry_id    <= offered.entry_id;
                    in_ch.search_key  <= offered.search_key;
                end
            end
            in_ch.valid <= offer_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results off out_ch, compares each against the oldest
    // awaited result, then holds ready low for a randomly drawn gap. A pending
    // hold-off keeps ready low regardless.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("with nothing awaited", results_seen,
                                    int'({out_ch.found, out_ch.position}), 0);
                else
                begin
                    lookup_result_t want;
                    want = awaited_results.pop_front();
                    if (out_ch.found !== want.found)
                        report_mismatch("found", results_seen,
                                        int'(out_ch.found), int'(want.found));
                    if (out_ch.position !== want.position)
                        report_mismatch("position", results_seen,
                                        int'(out_ch.position), int'(want.position));
                end
                results_seen++;
                if ($urandom_range(0, 49) == 0)
                    sink_steady = !sink_steady;
                sink_wait = draw_gap(sink_steady);
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= (choke_left == 0);
        end
    end

    // Hold-off counter: each new request restarts a long stall of out_ch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            choke_left <= 0;
        else if (choke_served != choke_requests)
        begin
            choke_served <= choke_requests;
            choke_left   <= CHOKE_CYCLES;
        end
        else if (choke_left != 0)
            choke_left <= choke_left - 1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Unused fields carry random bits so every input bit toggles.
    task automatic push_load(int idx, logic [IN_ID_W-1:0] id);
        table_word_t w;
        w.action      = ACT_LOAD;
        w.entry_index = IDX_W'(idx);
        w.entry_id    = id;
        w.search_key  = $urandom;
        queued_words.push_back(w);
        planned_ids[idx] = id;
        words_queued++;
    endtask

    task automatic push_search(logic [IN_ID_W-1:0] key);
        table_word_t w;
        w.action      = ACT_SEARCH;
        w.entry_index = IDX_W'($urandom);
        w.entry_id    = $urandom;
        w.search_key  = key;
        queued_words.push_back(w);
        words_queued++;
    endtask

    // Mostly keys that sit in the table, plus neighbors, extremes and noise
    function automatic logic [IN_ID_W-1:0] pick_key(int n);
        int sel;
        sel = $urandom_range(0, 9);
        if (n == 0 || sel >= 8)
            return $urandom;
        if (sel <= 4)
            return planned_ids[$urandom_range(0, n - 1)];
        if (sel == 5)
            return planned_ids[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        if (sel == 6)
            return '0;
        return '1;
    endfunction

    // Rewrite entries 0..n-1 in the requested layout
    task automatic fill_prefix(int n, fill_kind_t kind);
        bit [63:0] acc;
        bit [63:0] step;
        int        step_cap;
        acc      = 64'($urandom) >> $urandom_range(1, 32);
        step     = 1;
        step_cap = 1 << $urandom_range(2, 26);
        for (int i = 0; i < n; i++)
        begin
            if (kind == FILL_SHUFFLED)
                acc = 64'($urandom);
            push_load(i, acc[IN_ID_W-1:0]);
            case (kind)
                FILL_UNIFORM: acc += $urandom_range(0, step_cap);
                FILL_DUPES:   acc += ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50) : 0;
                FILL_SKEWED:
                begin
                    step = step * 2 + $urandom_range(0, 3);
                    if (step > 64'hFFFF_FFFF)
                        step = 64'hFFFF_FFFF;
                    acc += step;
                end
                default: ;
            endcase
            if (acc > 64'hFFFF_FFFF)
                acc = 64'hFFFF_FFFF;
        end
    endtask

    // All 1024 entries, nondecreasing from 0 to all-ones
    task automatic fill_whole_table();
        bit [63:0] acc;
        acc = 0;
        push_load(0, '0);
        for (int i = 1; i < TABLE_DEPTH - 1; i++)
        begin
            acc += $urandom_range(0, 8_000_000);
            if (acc > 64'hFFFF_FFFE)
                acc = 64'hFFFF_FFFE;
            push_load(i, acc[IN_ID_W-1:0]);
        end
        push_load(TABLE_DEPTH - 1, '1);
    endtask

    // Block idle: every word taken, every result back, load write settled.
    // Sampled on the falling edge so the driver's updates are already in.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_words.size() != 0 || in_ch.valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of entry_count: setup cycle, then access until pready
    task automatic write_entry_count(int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_setting = COUNT_W'(value);
        @(negedge clk);
    endtask

    // One phase: new count, optional prefix rewrite, then searches with a
    // sprinkling of stray loads. A choke phase lets the loads settle, then
    // stalls out_ch for a long stretch while the searches keep coming.
    task automatic run_phase(int count, fill_kind_t kind, int searches, bit choke);
        int n;
        wait_idle();
        write_entry_count(count);
        n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        if (kind != FILL_KEEP)
            fill_prefix(n, kind);
        if (choke)
        begin
            wait_idle();
            choke_requests <= choke_requests + 1;
        end
        repeat (searches)
        begin
            if ($urandom_range(0, 9) == 0)
                push_load($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            push_search(pick_key(n));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int         random_start;
        int         phase;
        int         sel;
        int         count;
        fill_kind_t kind;

        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table straight out of reset, then with count written as 0
        push_search('0);
        push_search('1);
        wait_idle();
        write_entry_count(0);
        push_search($urandom);

        // Whole table, then count beyond the table and count at the table size
        fill_whole_table();
        wait_idle();
        write_entry_count(MAX_COUNT);
        push_search('0);
        push_search('1);
        push_search(planned_ids[517]);
        push_search(planned_ids[517] + 1);
        wait_idle();
        write_entry_count(TABLE_DEPTH);
        push_search(planned_ids[1]);
        push_search(planned_ids[TABLE_DEPTH - 2]);

        // Single entry: hit, and keys just off either side
        wait_idle();
        write_entry_count(1);
        push_load(0, 32'h8000_0000);
        push_search(32'h8000_0000);
        push_search(32'h8000_0001);
        push_search(32'h7FFF_FFFF);

        // Two equal ids: the ids at both bounds are equal from the start
        wait_idle();
        write_entry_count(2);
        push_load(1, 32'h8000_0000);
        push_search(32'h8000_0000);
        push_search(32'h8000_0005);

        // Unsorted prefix: present keys can be missed, and the search must stay in range
        wait_idle();
        write_entry_count(4);
        push_load(0, 32'd10);
        push_load(1, 32'd50);
        push_load(2, 32'd20);
        push_load(3, 32'd60);
        push_search(32'd20);
        push_search(32'd55);
        push_search(32'd60);
        push_search(32'd50);

        // Random phases over a mostly small searched prefix
        random_start = words_queued;
        phase = 0;
        while (words_queued < random_start + RANDOM_WORDS)
        begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = FILL_UNIFORM;
                4, 5:       kind = FILL_DUPES;
                6:          kind = FILL_SKEWED;
                7, 8:       kind = FILL_SHUFFLED;
                default:    kind = FILL_FLAT;
            endcase
            if (sel < 5)
                count = 0;
            else if (sel < 10)
                count = $urandom_range(1, 2);
            else if (sel < 75)
                count = $urandom_range(3, 48);
            else if (sel < 90)
            begin
                count = $urandom_range(49, 256);
                if (kind == FILL_SKEWED)
                    kind = FILL_UNIFORM;
            end
            else if (sel < 95)
            begin
                count = $urandom_range(257, TABLE_DEPTH);
                kind  = FILL_KEEP;
            end
            else
            begin
                count = $urandom_range(TABLE_DEPTH + 1, MAX_COUNT);
                kind  = FILL_KEEP;
            end
            if (phase % 4 == 0)
                run_phase(count, kind, 40, 1'b1);
            else
                run_phase(count, kind, $urandom_range(4, 24), 1'b0);
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
